@@ rtl/one_wire_bus_master_macros.svh @@
// Assertion macros of the 1-Wire bus master RTL.
`ifndef ONE_WIRE_BUS_MASTER_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define OWM_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define OWM_ASSERT_IMPL(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define OWM_ASSERT_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/owm_pkg.sv @@
// Types, codes and constants of the 1-Wire bus master.
package owm_pkg;

   localparam int BITS_PER_BYTE = 8;

   // bus phases
   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_RST_LOW  = 3'd1;
   localparam logic [2:0] PH_RST_WAIT = 3'd2;
   localparam logic [2:0] PH_RST_TAIL = 3'd3;
   localparam logic [2:0] PH_SLOT     = 3'd4;
   localparam logic [2:0] PH_RECOV    = 3'd5;
   localparam logic [2:0] PH_CONV     = 3'd6;

   // request kinds and commands
   localparam logic       KIND_TICK    = 1'b0;
   localparam logic       KIND_COMMAND = 1'b1;
   localparam logic [1:0] CMD_RESET = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_TEMP  = 2'd3;

   // temperature transaction steps
   localparam logic [3:0] STEP_RESET1    = 4'd0;
   localparam logic [3:0] STEP_SKIP1     = 4'd1;
   localparam logic [3:0] STEP_CONVERT   = 4'd2;
   localparam logic [3:0] STEP_CONV_WAIT = 4'd3;
   localparam logic [3:0] STEP_RESET2    = 4'd4;
   localparam logic [3:0] STEP_SKIP2     = 4'd5;
   localparam logic [3:0] STEP_READ_SP   = 4'd6;
   localparam logic [3:0] STEP_READ_LSB  = 4'd7;
   localparam logic [3:0] STEP_READ_MSB  = 4'd8;

   // ROM and function commands
   localparam logic [7:0] ROM_SKIP     = 8'hCC;
   localparam logic [7:0] FN_CONVERT   = 8'h44;
   localparam logic [7:0] FN_READ_SP   = 8'hBE;
   localparam logic [7:0] READ_PATTERN = 8'hFF;

   // register indexes
   localparam logic [2:0] REG_SLOT_TIME   = 3'd0;
   localparam logic [2:0] REG_RESET_LOW   = 3'd1;
   localparam logic [2:0] REG_PRES_WAIT   = 3'd2;
   localparam logic [2:0] REG_RESET_TAIL  = 3'd3;
   localparam logic [2:0] REG_READ_SAMPLE = 3'd4;
   localparam logic [2:0] REG_RECOVERY    = 3'd5;
   localparam logic [2:0] REG_CONV_WAIT   = 3'd6;

   // register reset values
   localparam logic [7:0]  RST_SLOT_TIME   = 8'd50;
   localparam logic [9:0]  RST_RESET_LOW   = 10'd480;
   localparam logic [7:0]  RST_PRES_WAIT   = 8'd80;
   localparam logic [9:0]  RST_RESET_TAIL  = 10'd400;
   localparam logic [5:0]  RST_READ_SAMPLE = 6'd12;
   localparam logic [5:0]  RST_RECOVERY    = 6'd2;
   localparam logic [19:0] RST_CONV_WAIT   = 20'd800;

   typedef struct packed {
      logic [7:0]  slot_time_us;
      logic [9:0]  reset_low_us;
      logic [7:0]  presence_wait_us;
      logic [9:0]  reset_tail_us;
      logic [5:0]  read_sample_us;
      logic [5:0]  recovery_us;
      logic [19:0] conversion_wait_ticks;
   } cfg_type;

   typedef struct packed {
      logic       kind;
      logic [1:0] command;
      logic [7:0] data_byte;
      logic       line_level;
   } req_type;

   typedef struct packed {
      logic        drive_low;
      logic        busy_res;
      logic        done_res;
      logic        presence_ok;
      logic [7:0]  read_data;
      logic [15:0] temperature_raw;
   } rsp_type;

   // Byte sent by a byte step of the temperature transaction.
   function automatic logic [7:0] step_byte(input logic [3:0] step);
      logic [7:0] b;
      case (step) inside
         STEP_SKIP1, STEP_SKIP2: b = ROM_SKIP;
         STEP_CONVERT:           b = FN_CONVERT;
         STEP_READ_SP:           b = FN_READ_SP;
         default:                b = READ_PATTERN;
      endcase
      return b;
   endfunction

   // True while the current byte is a read.
   function automatic logic is_reading(input logic [1:0] cmd, input logic [3:0] step);
      return (cmd == CMD_READ) ||
             (cmd == CMD_TEMP && (step == STEP_READ_LSB || step == STEP_READ_MSB));
   endfunction

endpackage

@@ rtl/owm_channels.sv @@
// Request and response channel interfaces of the 1-Wire bus master.
interface owm_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [1:0] command;
   logic [7:0] data_byte;
   logic       line_level;

   modport source (output valid, kind, command, data_byte, line_level, input ready);
   modport sink (input valid, kind, command, data_byte, line_level, output ready);
endinterface

interface owm_rsp_if;
   logic        valid;
   logic        ready;
   logic        drive_low;
   logic        busy_res;
   logic        done_res;
   logic        presence_ok;
   logic [7:0]  read_data;
   logic [15:0] temperature_raw;

   modport source (output valid, drive_low, busy_res, done_res, presence_ok, read_data,
                   temperature_raw, input ready);
   modport sink (input valid, drive_low, busy_res, done_res, presence_ok, read_data,
                 temperature_raw, output ready);
endinterface

@@ rtl/owm_csr.sv @@
// APB-style configuration registers of the 1-Wire bus master.
module owm_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output owm_pkg::cfg_type  cfg
);

   owm_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [2:0]       reg_index;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            owm_pkg::REG_SLOT_TIME:   cfg_in.slot_time_us          = csr_pwdata[7:0];
            owm_pkg::REG_RESET_LOW:   cfg_in.reset_low_us          = csr_pwdata[9:0];
            owm_pkg::REG_PRES_WAIT:   cfg_in.presence_wait_us      = csr_pwdata[7:0];
            owm_pkg::REG_RESET_TAIL:  cfg_in.reset_tail_us         = csr_pwdata[9:0];
            owm_pkg::REG_READ_SAMPLE: cfg_in.read_sample_us        = csr_pwdata[5:0];
            owm_pkg::REG_RECOVERY:    cfg_in.recovery_us           = csr_pwdata[5:0];
            owm_pkg::REG_CONV_WAIT:   cfg_in.conversion_wait_ticks = csr_pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         owm_pkg::REG_SLOT_TIME:   csr_prdata = {24'd0, cfg_ff.slot_time_us};
         owm_pkg::REG_RESET_LOW:   csr_prdata = {22'd0, cfg_ff.reset_low_us};
         owm_pkg::REG_PRES_WAIT:   csr_prdata = {24'd0, cfg_ff.presence_wait_us};
         owm_pkg::REG_RESET_TAIL:  csr_prdata = {22'd0, cfg_ff.reset_tail_us};
         owm_pkg::REG_READ_SAMPLE: csr_prdata = {26'd0, cfg_ff.read_sample_us};
         owm_pkg::REG_RECOVERY:    csr_prdata = {26'd0, cfg_ff.recovery_us};
         owm_pkg::REG_CONV_WAIT:   csr_prdata = {12'd0, cfg_ff.conversion_wait_ticks};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot_time_us          <= owm_pkg::RST_SLOT_TIME;
         cfg_ff.reset_low_us          <= owm_pkg::RST_RESET_LOW;
         cfg_ff.presence_wait_us      <= owm_pkg::RST_PRES_WAIT;
         cfg_ff.reset_tail_us         <= owm_pkg::RST_RESET_TAIL;
         cfg_ff.read_sample_us        <= owm_pkg::RST_READ_SAMPLE;
         cfg_ff.recovery_us           <= owm_pkg::RST_RECOVERY;
         cfg_ff.conversion_wait_ticks <= owm_pkg::RST_CONV_WAIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/owm_engine.sv @@
// Bus timing state machine: advances one step per fired request.
module owm_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  owm_pkg::req_type  item,
   input  owm_pkg::cfg_type  cfg,
   output owm_pkg::rsp_type  result
);

   logic [2:0]  phase_ff, phase_in;
   logic [19:0] tick_ff, tick_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [3:0]  step_ff, step_in;
   logic [7:0]  low_ff, low_in;
   logic [15:0] temp_ff, temp_in;
   logic        presence_ff, presence_in;
   logic [1:0]  active_ff, active_in;
   logic [7:0]  last_read_ff, last_read_in;

   logic [19:0] tick_next;
   logic [19:0] dur_reset_low, dur_pres, dur_tail, dur_recov, dur_conv, dur_slot;
   logic [7:0]  slot_len, sample_pt;
   logic        rd_now, unit_end, done;

   always_comb begin
      tick_next = tick_ff + 20'd1;
      // a zero register counts as one tick
      dur_reset_low = (cfg.reset_low_us == '0) ? 20'd1 : {10'd0, cfg.reset_low_us};
      dur_pres  = (cfg.presence_wait_us == '0) ? 20'd1 : {12'd0, cfg.presence_wait_us};
      dur_tail  = (cfg.reset_tail_us == '0) ? 20'd1 : {10'd0, cfg.reset_tail_us};
      dur_recov = (cfg.recovery_us == '0) ? 20'd1 : {14'd0, cfg.recovery_us};
      dur_conv  = (cfg.conversion_wait_ticks == '0) ? 20'd1 : cfg.conversion_wait_ticks;
      slot_len  = (cfg.slot_time_us == '0) ? 8'd1 : cfg.slot_time_us;
      dur_slot  = {12'd0, slot_len};
      sample_pt = (cfg.read_sample_us == '0) ? 8'd1 : {2'd0, cfg.read_sample_us};
      if (sample_pt > slot_len) begin
         sample_pt = slot_len;
      end
      rd_now = owm_pkg::is_reading(active_ff, step_ff);
   end

   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      step_in      = step_ff;
      low_in       = low_ff;
      temp_in      = temp_ff;
      presence_in  = presence_ff;
      active_in    = active_ff;
      last_read_in = last_read_ff;
      unit_end     = 1'b0;
      done         = 1'b0;

      if (item.kind == owm_pkg::KIND_COMMAND) begin
         if (phase_ff == owm_pkg::PH_IDLE) begin
            active_in = item.command;
            step_in   = owm_pkg::STEP_RESET1;
            tick_in   = '0;
            bit_in    = '0;
            case (item.command) inside
               owm_pkg::CMD_RESET, owm_pkg::CMD_TEMP: phase_in = owm_pkg::PH_RST_LOW;
               owm_pkg::CMD_WRITE: begin
                  phase_in = owm_pkg::PH_SLOT;
                  shift_in = item.data_byte;
               end
               default: begin
                  phase_in = owm_pkg::PH_SLOT;
                  shift_in = owm_pkg::READ_PATTERN;
               end
            endcase
         end
      end else if (phase_ff != owm_pkg::PH_IDLE) begin
         tick_in = tick_next;
         unique case (phase_ff)
            owm_pkg::PH_RST_LOW: begin
               if (tick_next >= dur_reset_low) begin
                  phase_in = owm_pkg::PH_RST_WAIT;
                  tick_in  = '0;
               end
            end
            owm_pkg::PH_RST_WAIT: begin
               if (tick_next >= dur_pres) begin
                  presence_in = ~item.line_level;
                  phase_in    = owm_pkg::PH_RST_TAIL;
                  tick_in     = '0;
               end
            end
            owm_pkg::PH_RST_TAIL: begin
               unit_end = (tick_next >= dur_tail);
            end
            owm_pkg::PH_SLOT: begin
               if (rd_now && tick_next == {12'd0, sample_pt}) begin
                  shift_in = {item.line_level, shift_ff[7:1]};
               end
               if (tick_next >= dur_slot) begin
                  if (!rd_now) begin
                     shift_in = {1'b0, shift_ff[7:1]};
                  end
                  phase_in = owm_pkg::PH_RECOV;
                  tick_in  = '0;
               end
            end
            owm_pkg::PH_RECOV: begin
               if (tick_next >= dur_recov) begin
                  if (bit_ff == 3'(owm_pkg::BITS_PER_BYTE - 1)) begin
                     if (rd_now) begin
                        last_read_in = shift_ff;
                     end
                     unit_end = 1'b1;
                  end else begin
                     bit_in   = bit_ff + 3'd1;
                     phase_in = owm_pkg::PH_SLOT;
                     tick_in  = '0;
                  end
               end
            end
            owm_pkg::PH_CONV: begin
               unit_end = (tick_next >= dur_conv);
            end
            default: begin
               phase_in = owm_pkg::PH_IDLE;
               tick_in  = '0;
               done     = 1'b1;
            end
         endcase
      end

      // finish the operation or chain into the next transaction step
      if (unit_end) begin
         if (active_ff != owm_pkg::CMD_TEMP || step_ff >= owm_pkg::STEP_READ_MSB) begin
            if (active_ff == owm_pkg::CMD_TEMP) begin
               temp_in = {shift_in, low_ff};
            end
            phase_in = owm_pkg::PH_IDLE;
            tick_in  = '0;
            done     = 1'b1;
         end else begin
            if (step_ff == owm_pkg::STEP_READ_LSB) begin
               low_in = shift_in;
            end
            step_in = step_ff + 4'd1;
            tick_in = '0;
            bit_in  = '0;
            case (step_in) inside
               owm_pkg::STEP_RESET1, owm_pkg::STEP_RESET2: phase_in = owm_pkg::PH_RST_LOW;
               owm_pkg::STEP_CONV_WAIT: phase_in = owm_pkg::PH_CONV;
               default: begin
                  phase_in = owm_pkg::PH_SLOT;
                  shift_in = owm_pkg::step_byte(step_in);
               end
            endcase
         end
      end
   end

   always_comb begin
      result.drive_low = (phase_in == owm_pkg::PH_RST_LOW) ||
                         (phase_in == owm_pkg::PH_SLOT &&
                          (tick_in == '0 ||
                           (!owm_pkg::is_reading(active_in, step_in) && !shift_in[0])));
      result.busy_res        = (phase_in != owm_pkg::PH_IDLE);
      result.done_res        = done;
      result.presence_ok     = presence_in;
      result.read_data       = last_read_in;
      result.temperature_raw = temp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= owm_pkg::PH_IDLE;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         step_ff      <= '0;
         low_ff       <= '0;
         temp_ff      <= '0;
         presence_ff  <= 1'b0;
         active_ff    <= '0;
         last_read_ff <= '0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         step_ff      <= step_in;
         low_ff       <= low_in;
         temp_ff      <= temp_in;
         presence_ff  <= presence_in;
         active_ff    <= active_in;
         last_read_ff <= last_read_in;
      end
   end

endmodule

@@ rtl/one_wire_bus_master.sv @@
// 1-Wire bus master driven by microsecond tick and command requests.
// Usage:
//   req carries one request per accepted handshake: a microsecond tick
//   (kind 0, with the sampled bus level) or a command (kind 1: reset,
//   write byte, read byte, temperature transaction).
//   rsp returns exactly one response per request: line drive for the next
//   microsecond, busy, done, presence, last read byte, raw temperature.
//   csr is an APB-style port; registers sit at byte address 4*index and
//   must be written only while the master is idle; the block does not enforce it.
// Pipeline:
//   A request is taken into an input register, processed by the bus state
//   machine once the output register is free, and its response is then
//   held in the output register. One request is accepted every cycle while
//   rsp is not stalled; the engine updates its state once per request.
// Reset:
//   Synchronous reset empties both pipeline registers, returns the bus
//   state machine to idle and loads the register defaults.
// Stall:
//   A stalled rsp holds its response; the input register still fills, then
//   req.ready drops until rsp drains.
`include "one_wire_bus_master_macros.svh"

module one_wire_bus_master (
   input  logic        clock,
   input  logic        reset,
   owm_req_if.sink     req,
   owm_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   owm_pkg::cfg_type cfg;
   owm_pkg::req_type item_ff, item_in;
   owm_pkg::rsp_type result;
   owm_pkg::rsp_type out_ff, out_in;
   logic             item_valid_ff, item_valid_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_free, fire, req_take;

   owm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   owm_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign out_free  = !out_valid_ff || rsp.ready;
   assign fire      = item_valid_ff && out_free;
   assign req.ready = !item_valid_ff || out_free;
   assign req_take  = req.valid && req.ready;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (req_take) begin
         item_in.kind       = req.kind;
         item_in.command    = req.command;
         item_in.data_byte  = req.data_byte;
         item_in.line_level = req.line_level;
         item_valid_in      = 1'b1;
      end else if (fire) begin
         item_valid_in = 1'b0;
      end

      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_in       = result;
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      item_ff <= item_in;
      out_ff  <= out_in;
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.drive_low       = out_ff.drive_low;
   assign rsp.busy_res        = out_ff.busy_res;
   assign rsp.done_res        = out_ff.done_res;
   assign rsp.presence_ok     = out_ff.presence_ok;
   assign rsp.read_data       = out_ff.read_data;
   assign rsp.temperature_raw = out_ff.temperature_raw;

   `OWM_ASSERT_IMPL(a_drive_only_busy, out_valid_ff && out_ff.drive_low, out_ff.busy_res, "bus driven low while idle")
   `OWM_ASSERT_IMPL(a_done_not_busy, out_valid_ff && out_ff.done_res, !out_ff.busy_res, "done reported while still busy")
   `OWM_ASSERT_NEXT(a_fire_fills_out, fire, out_valid_ff, "processed request lost its response")
   `OWM_ASSERT(a_full_blocks_req, !(item_valid_ff && out_valid_ff && !rsp.ready) || !req.ready, "request taken while pipeline full")

endmodule

@@ verif/tb.sv @@
// Self-checking testbench of the 1-Wire bus master: request driver, bus predictor, response check.
module tb;
   import owm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 40;
   localparam int STRAY_PCT      = 2;

   typedef enum logic [1:0] {PLAN_NONE, PLAN_LOW, PLAN_HIGH, PLAN_MIXED} line_plan_e;

   typedef struct {
      req_type    rq;
      logic       typed;
      rsp_type    want;
      line_plan_e plan;
   } stim_row_t;

   localparam rsp_type IDLE_STATUS  = '0;
   localparam rsp_type RESET_START  = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 16'h0000};
   localparam rsp_type WRITE0_START = '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 16'h0000};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic        csr_pready;

   owm_req_if req_ch();
   owm_rsp_if rsp_ch();

   one_wire_bus_master dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // bus master predictor state
   cfg_type     bus_cfg;
   logic [2:0]  bus_phase;
   logic [19:0] phase_ticks;
   logic [2:0]  bit_pos;
   logic [7:0]  shift_reg;
   logic [3:0]  txn_step;
   logic [7:0]  lsb_hold;
   logic [15:0] temp_hold;
   logic        presence_seen;
   logic [1:0]  cur_cmd;
   logic [7:0]  last_byte_read;
   logic        op_finished;

   rsp_type     expected_status[$];
   logic        typed_pending = 1'b0;
   rsp_type     typed_value   = '0;
   int          accepted_requests = 0;
   int          checked_responses = 0;
   int          settings_applied  = 0;
   int          error_count       = 0;
   int          quiet_cycles      = 0;
   int          src_idle_pct      = 11;
   int          snk_idle_pct      = 71;
   stim_row_t   directed [14];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned span(input int unsigned v);
      return (v == 0) ? 1 : v;
   endfunction

   function automatic logic reads_now();
      return cur_cmd == CMD_READ ||
             (cur_cmd == CMD_TEMP && (txn_step == STEP_READ_LSB || txn_step == STEP_READ_MSB));
   endfunction

   function automatic void launch_byte(input logic [7:0] b);
      bus_phase   = PH_SLOT;
      phase_ticks = '0;
      bit_pos     = '0;
      shift_reg   = b;
   endfunction

   function automatic void launch_reset();
      bus_phase   = PH_RST_LOW;
      phase_ticks = '0;
   endfunction

   function automatic void launch_step(input logic [3:0] s);
      case (s)
         STEP_RESET1, STEP_RESET2: launch_reset();
         STEP_SKIP1, STEP_SKIP2:   launch_byte(ROM_SKIP);
         STEP_CONVERT:             launch_byte(FN_CONVERT);
         STEP_CONV_WAIT: begin
            bus_phase   = PH_CONV;
            phase_ticks = '0;
         end
         STEP_READ_SP:             launch_byte(FN_READ_SP);
         default:                  launch_byte(READ_PATTERN);
      endcase
   endfunction

   function automatic void close_op();
      bus_phase   = PH_IDLE;
      phase_ticks = '0;
      op_finished = 1'b1;
   endfunction

   function automatic void wrap_up_unit();
      if (cur_cmd != CMD_TEMP) begin
         close_op();
         return;
      end
      if (txn_step == STEP_READ_LSB) lsb_hold = shift_reg;
      if (txn_step >= STEP_READ_MSB) begin
         temp_hold = {shift_reg, lsb_hold};
         close_op();
         return;
      end
      txn_step = txn_step + 4'd1;
      launch_step(txn_step);
   endfunction

   // Advance the bus model by one request and return the status it reports.
   function automatic rsp_type predict_bus(input req_type r);
      int unsigned slot;
      int unsigned smp;
      logic        rd;
      rsp_type     o;
      op_finished = 1'b0;
      if (r.kind == KIND_COMMAND) begin
         if (bus_phase == PH_IDLE) begin
            cur_cmd  = r.command;
            txn_step = STEP_RESET1;
            case (r.command)
               CMD_TEMP:  launch_step(STEP_RESET1);
               CMD_RESET: launch_reset();
               CMD_WRITE: launch_byte(r.data_byte);
               default:   launch_byte(READ_PATTERN);
            endcase
         end
      end else if (bus_phase != PH_IDLE) begin
         phase_ticks = phase_ticks + 20'd1;
         case (bus_phase)
            PH_RST_LOW:
               if (phase_ticks >= span(bus_cfg.reset_low_us)) begin
                  bus_phase   = PH_RST_WAIT;
                  phase_ticks = '0;
               end
            PH_RST_WAIT:
               if (phase_ticks >= span(bus_cfg.presence_wait_us)) begin
                  presence_seen = ~r.line_level;
                  bus_phase     = PH_RST_TAIL;
                  phase_ticks   = '0;
               end
            PH_RST_TAIL:
               if (phase_ticks >= span(bus_cfg.reset_tail_us)) wrap_up_unit();
            PH_SLOT: begin
               slot = span(bus_cfg.slot_time_us);
               smp  = span(bus_cfg.read_sample_us);
               rd   = reads_now();
               // a late sample point falls back to the last tick of the slot
               if (smp > slot) smp = slot;
               if (rd && phase_ticks == smp) shift_reg = {r.line_level, shift_reg[7:1]};
               if (phase_ticks >= slot) begin
                  if (!rd) shift_reg = shift_reg >> 1;
                  bus_phase   = PH_RECOV;
                  phase_ticks = '0;
               end
            end
            PH_RECOV:
               if (phase_ticks >= span(bus_cfg.recovery_us)) begin
                  if (int'(bit_pos) >= BITS_PER_BYTE - 1) begin
                     if (reads_now()) last_byte_read = shift_reg;
                     wrap_up_unit();
                  end else begin
                     bit_pos     = bit_pos + 3'd1;
                     bus_phase   = PH_SLOT;
                     phase_ticks = '0;
                  end
               end
            PH_CONV:
               if (phase_ticks >= span(bus_cfg.conversion_wait_ticks)) wrap_up_unit();
            default: close_op();
         endcase
      end
      o = '0;
      if (bus_phase == PH_RST_LOW) o.drive_low = 1'b1;
      else if (bus_phase == PH_SLOT)
         o.drive_low = (phase_ticks == 0) || (!reads_now() && !shift_reg[0]);
      o.busy_res        = (bus_phase != PH_IDLE);
      o.done_res        = op_finished;
      o.presence_ok     = presence_seen;
      o.read_data       = last_byte_read;
      o.temperature_raw = temp_hold;
      return o;
   endfunction

   function automatic void apply_setting(input logic [2:0] idx, input logic [19:0] v);
      case (idx)
         REG_SLOT_TIME:   bus_cfg.slot_time_us          = v[7:0];
         REG_RESET_LOW:   bus_cfg.reset_low_us          = v[9:0];
         REG_PRES_WAIT:   bus_cfg.presence_wait_us      = v[7:0];
         REG_RESET_TAIL:  bus_cfg.reset_tail_us         = v[9:0];
         REG_READ_SAMPLE: bus_cfg.read_sample_us        = v[5:0];
         REG_RECOVERY:    bus_cfg.recovery_us           = v[5:0];
         REG_CONV_WAIT:   bus_cfg.conversion_wait_ticks = v;
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string field, input logic [15:0] want,
                                       input logic [15:0] seen);
      if (seen !== want) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, seen);
      end
   endfunction

   function automatic cfg_type small_settings();
      cfg_type c;
      c.slot_time_us          = 8'($urandom_range(10, 2));
      c.reset_low_us          = 10'($urandom_range(24, 1));
      c.presence_wait_us      = 8'($urandom_range(10, 1));
      c.reset_tail_us         = 10'($urandom_range(24, 1));
      c.read_sample_us        = 6'($urandom_range(12, 1));
      c.recovery_us           = 6'($urandom_range(4, 1));
      c.conversion_wait_ticks = 20'($urandom_range(40, 1));
      return c;
   endfunction

   // Score responses and predict each accepted request.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type seen;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = '{rsp_ch.drive_low, rsp_ch.busy_res, rsp_ch.done_res, rsp_ch.presence_ok,
                     rsp_ch.read_data, rsp_ch.temperature_raw};
            if (expected_status.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: response with nothing expected, got 0x%0h", $time, seen);
            end else begin
               want = expected_status.pop_front();
               check_field("drive_low", 16'(want.drive_low), 16'(seen.drive_low));
               check_field("busy_res", 16'(want.busy_res), 16'(seen.busy_res));
               check_field("done_res", 16'(want.done_res), 16'(seen.done_res));
               check_field("presence_ok", 16'(want.presence_ok), 16'(seen.presence_ok));
               check_field("read_data", 16'(want.read_data), 16'(seen.read_data));
               check_field("temperature_raw", want.temperature_raw, seen.temperature_raw);
               checked_responses++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            want = predict_bus('{req_ch.kind, req_ch.command, req_ch.data_byte,
                                 req_ch.line_level});
            if (typed_pending) want = typed_value;
            expected_status.push_back(want);
            accepted_requests++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("one_wire_bus_master verification failed");
            $finish;
         end
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
   end

   task automatic send_request(input req_type r, input logic typed, input rsp_type want);
      int target;
      if ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      typed_pending = typed;
      typed_value   = want;
      target        = accepted_requests + 1;
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= r.kind;
      req_ch.command    <= r.command;
      req_ch.data_byte  <= r.data_byte;
      req_ch.line_level <= r.line_level;
      do @(negedge clock); while (accepted_requests != target);
      typed_pending = 1'b0;
   endtask

   // Feed microsecond ticks until the operation ends, now and then a command while busy.
   task automatic tick_until_idle(input line_plan_e plan, input int stray_pct);
      req_type r;
      while (bus_phase != PH_IDLE) begin
         r.kind       = KIND_TICK;
         r.command    = 2'($urandom);
         r.data_byte  = 8'($urandom);
         r.line_level = (plan == PLAN_LOW) ? 1'b0 : (plan == PLAN_HIGH) ? 1'b1 : 1'($urandom);
         if ($urandom_range(99) < stray_pct) r.kind = KIND_COMMAND;
         send_request(r, 1'b0, '0);
      end
   endtask

   task automatic run_random_op(input logic allow_temp);
      req_type    r;
      line_plan_e plan;
      if ($urandom_range(9) == 0) begin
         r = '{KIND_TICK, 2'($urandom), 8'($urandom), 1'($urandom)};
         send_request(r, 1'b0, '0);
      end
      r.kind       = KIND_COMMAND;
      r.command    = allow_temp ? 2'($urandom_range(int'(CMD_TEMP)))
                                : 2'($urandom_range(int'(CMD_READ)));
      r.data_byte  = 8'($urandom);
      r.line_level = 1'($urandom);
      send_request(r, 1'b0, '0);
      case ($urandom_range(3))
         0:       plan = PLAN_LOW;
         1:       plan = PLAN_HIGH;
         default: plan = PLAN_MIXED;
      endcase
      tick_until_idle(plan, STRAY_PCT);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [19:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      apply_setting(idx, value);
   endtask

   // Drain, let the pipeline settle, then load a full register set and set the idle rates.
   task automatic program_settings(input cfg_type c, input int idle_mode);
      req_ch.valid <= 1'b0;
      while (expected_status.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_register(REG_SLOT_TIME, 20'(c.slot_time_us));
      write_register(REG_RESET_LOW, 20'(c.reset_low_us));
      write_register(REG_PRES_WAIT, 20'(c.presence_wait_us));
      write_register(REG_RESET_TAIL, 20'(c.reset_tail_us));
      write_register(REG_READ_SAMPLE, 20'(c.read_sample_us));
      write_register(REG_RECOVERY, 20'(c.recovery_us));
      write_register(REG_CONV_WAIT, c.conversion_wait_ticks);
      settings_applied++;
      case (idle_mode)
         0: begin
            src_idle_pct = 11;
            snk_idle_pct = 71;
         end
         1: begin
            src_idle_pct = 71;
            snk_idle_pct = 11;
         end
         default: begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
         end
      endcase
   endtask

   initial begin
      cfg_type c;
      req_ch.valid      = 1'b0;
      req_ch.kind       = KIND_TICK;
      req_ch.command    = CMD_RESET;
      req_ch.data_byte  = 8'h00;
      req_ch.line_level = 1'b1;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;

      bus_cfg        = '{RST_SLOT_TIME, RST_RESET_LOW, RST_PRES_WAIT, RST_RESET_TAIL,
                         RST_READ_SAMPLE, RST_RECOVERY, RST_CONV_WAIT};
      bus_phase      = PH_IDLE;
      phase_ticks    = '0;
      bit_pos        = '0;
      shift_reg      = '0;
      txn_step       = STEP_RESET1;
      lsb_hold       = '0;
      temp_hold      = '0;
      presence_seen  = 1'b0;
      cur_cmd        = CMD_RESET;
      last_byte_read = '0;
      op_finished    = 1'b0;

      // ticks while idle, commands while busy, byte and bus-level extremes
      directed[0]  = '{'{KIND_TICK, CMD_TEMP, 8'hFF, 1'b1}, 1'b1, IDLE_STATUS, PLAN_NONE};
      directed[1]  = '{'{KIND_TICK, CMD_RESET, 8'h00, 1'b0}, 1'b1, IDLE_STATUS, PLAN_NONE};
      directed[2]  = '{'{KIND_COMMAND, CMD_RESET, 8'h00, 1'b1}, 1'b1, RESET_START, PLAN_NONE};
      directed[3]  = '{'{KIND_COMMAND, CMD_TEMP, 8'hFF, 1'b0}, 1'b1, RESET_START, PLAN_LOW};
      directed[4]  = '{'{KIND_COMMAND, CMD_WRITE, 8'h00, 1'b1}, 1'b1, WRITE0_START, PLAN_HIGH};
      directed[5]  = '{'{KIND_COMMAND, CMD_WRITE, 8'hFF, 1'b0}, 1'b0, IDLE_STATUS, PLAN_HIGH};
      directed[6]  = '{'{KIND_COMMAND, CMD_READ, 8'h5A, 1'b1}, 1'b0, IDLE_STATUS, PLAN_LOW};
      directed[7]  = '{'{KIND_COMMAND, CMD_READ, 8'hA5, 1'b0}, 1'b0, IDLE_STATUS, PLAN_HIGH};
      directed[8]  = '{'{KIND_COMMAND, CMD_READ, 8'h00, 1'b1}, 1'b0, IDLE_STATUS, PLAN_MIXED};
      directed[9]  = '{'{KIND_COMMAND, CMD_TEMP, 8'h00, 1'b1}, 1'b0, IDLE_STATUS, PLAN_LOW};
      directed[10] = '{'{KIND_COMMAND, CMD_TEMP, 8'hFF, 1'b1}, 1'b0, IDLE_STATUS, PLAN_HIGH};
      directed[11] = '{'{KIND_COMMAND, CMD_RESET, 8'h3C, 1'b0}, 1'b0, IDLE_STATUS, PLAN_MIXED};
      directed[12] = '{'{KIND_TICK, CMD_WRITE, 8'hFF, 1'b1}, 1'b0, IDLE_STATUS, PLAN_NONE};
      directed[13] = '{'{KIND_COMMAND, CMD_WRITE, 8'hA5, 1'b1}, 1'b0, IDLE_STATUS, PLAN_MIXED};

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) begin
         send_request(directed[i].rq, directed[i].typed, directed[i].want);
         if (directed[i].plan != PLAN_NONE) tick_until_idle(directed[i].plan, 0);
      end

      program_settings(small_settings(), 0);
      repeat (120) run_random_op(1'b1);

      // zero registers act as one-tick durations
      program_settings('0, 0);
      repeat (50) run_random_op(1'b1);

      program_settings('{8'd1, 10'd1, 8'd1, 10'd1, 6'd1, 6'd1, 20'd1}, 1);
      repeat (50) run_random_op(1'b1);

      // read sample point at or past the end of the slot
      c = small_settings();
      c.read_sample_us = 6'($urandom_range(63, int'(c.slot_time_us)));
      program_settings(c, 1);
      repeat (60) run_random_op(1'b1);

      program_settings(small_settings(), 2);
      repeat (120) run_random_op(1'b1);

      // longest timings: skip the transaction, whose conversion wait would dominate the run
      program_settings('{8'hFF, 10'h3FF, 8'hFF, 10'h3FF, 6'h3F, 6'h3F, 20'hFFFFF}, 2);
      repeat (4) run_random_op(1'b0);

      req_ch.valid <= 1'b0;
      while (expected_status.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (expected_status.size() != 0) begin
         error_count++;
         $display("%0t: %0d responses never arrived", $time, expected_status.size());
      end

      $display("Covered %0d requests, %0d responses checked, over %0d register sets",
               accepted_requests, checked_responses, settings_applied + 1);
      $display("(reset defaults, short, zero, minimum, late-sample and maximum timings).");
      if (error_count == 0) begin
         $display("one_wire_bus_master verification clean");
      end else begin
         $display("one_wire_bus_master verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/owm_pkg.sv
rtl/owm_channels.sv
rtl/owm_csr.sv
rtl/owm_engine.sv
rtl/one_wire_bus_master.sv
verif/tb.sv
